[hw/rtl/rlpf_pkg.sv]
// Shared constants, register codes and controller/datapath types of the red run-length filter.
`timescale 1ns / 1ps

package rlpf_pkg;

  // Frame and run limits.
  localparam int MAX_WIDTH  = 640;
  localparam int MAX_HEIGHT = 480;
  localparam int MAX_RUN    = 120;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam int AW_W        = $clog2(MAX_WIDTH + 1);
  localparam int AH_W        = $clog2(MAX_HEIGHT + 1);
  localparam int DIST_W      = (AW_W > AH_W) ? AW_W : AH_W;
  localparam int RUN_W       = $clog2(MAX_RUN + 1);
  localparam int DIV_CNT_W   = $clog2(POS_W);

  // Pixel and register field widths.
  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 3 * CHAN_W;
  localparam int FLOOR_W      = 8;
  localparam int MARGIN_W     = 8;
  localparam int RUN_NEEDED_W = 7;
  localparam int FW_W         = 10;
  localparam int FH_W         = 9;

  // Register file.
  localparam int NUM_REGS  = 5;
  localparam int PADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int PDATA_W   = 32;

  localparam logic [FLOOR_W-1:0]      RST_RED_FLOOR    = 8'd150;
  localparam logic [MARGIN_W-1:0]     RST_RED_MARGIN   = 8'd50;
  localparam logic [RUN_NEEDED_W-1:0] RST_RUN_NEEDED   = 7'd115;
  localparam logic [FW_W-1:0]         RST_FRAME_WIDTH  = 10'd640;
  localparam logic [FH_W-1:0]         RST_FRAME_HEIGHT = 9'd480;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RED_FLOOR,
    REG_RED_MARGIN,
    REG_RUN_NEEDED,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } reg_idx_t;

  // Settings as the datapath sees them; frame size already clamped.
  typedef struct packed {
    logic [FLOOR_W-1:0]      red_floor;
    logic [MARGIN_W-1:0]     red_margin;
    logic [RUN_NEEDED_W-1:0] run_needed;
    logic [AW_W-1:0]         active_w;
    logic [AH_W-1:0]         active_h;
    logic [POS_W-1:0]        total;
  } cfg_t;

  typedef struct packed {
    logic take_item;
    logic pos_set;
    logic load_write;
    logic div_step;
    logic center_read;
    logic center_latch;
    logic dir_init;
    logic walk_step;
    logic dir_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic div_done;
    logic center_red;
    logic walk_done;
    logic walk_keep;
    logic last_dir;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/rlpf_if.sv]
// Input and output channel interfaces of the red run-length filter.
`timescale 1ns / 1ps

interface rlpf_in_if import rlpf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] red_in;

  modport source (output valid, mode, blue_in, green_in, red_in, input ready);
  modport sink (input valid, mode, blue_in, green_in, red_in, output ready);
endinterface

interface rlpf_out_if import rlpf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] red_out;
  logic              kept;
  logic              frame_end;

  modport source (output valid, blue_out, green_out, red_out, kept, frame_end, input ready);
  modport sink (input valid, blue_out, green_out, red_out, kept, frame_end, output ready);
endinterface

[hw/rtl/red_run_length_pixel_filter.sv]
// Top level of the red run-length pixel filter: channels, register port, controller and datapath.
`timescale 1ns / 1ps

// A frame of BGR pixels is written into an on-chip frame store with load beats (mode 0) in
// raster order, and readout beats (mode 1) return one filtered pixel each, in the same order.
// A readout pixel is passed through only if it is red and, in at least one of the directions
// right, left, down and up, more than run_needed consecutive neighbors are red as well; all
// other pixels come out black with kept low, and frame_end marks the frame's last pixel. The
// block works on one beat at a time. A load beat passes through setup and the store write
// before the next beat can be accepted. A readout beat passes through setup, the column/row
// divide (one quotient bit per cycle over the 19-bit position), the center read and the
// hand-off of the result before the next beat can be accepted. Between the center read and
// the hand-off, a red pixel examines the directions in turn, each with a direction setup and
// a walk that reads its neighbors one at a time, since the single read port of the frame
// store delivers one pixel per cycle. A finished result waits in the output register and a new
// beat is accepted while it does; the next result waits until that register is free. The
// frame store has no reset: read a position only after it has been loaded. Write settings
// over the APB port only while the block is idle; the block itself does not enforce this. A new
// frame size reaches the datapath through the raw register and then the registered geometry.
module red_run_length_pixel_filter import rlpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rlpf_in_if.sink            pix_in,
  rlpf_out_if.source         pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t             cfg;
  cmd_t             cmd;
  stat_t            stat;
  logic             in_ready;
  logic [PIX_W-1:0] in_pix;

  // The frame store keeps blue in the low byte and red in the high byte.
  assign in_pix       = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
  assign pix_in.ready = in_ready;

  // Settings registers; the clamped frame size and pixel count are computed here.
  rlpf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller accepts a beat only in its idle state and then steps the datapath.
  rlpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the frame store, the positions and the output register.
  rlpf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .in_mode       (pix_in.mode),
    .in_pix        (in_pix),
    .out_ready     (pix_out.ready),
    .out_valid     (pix_out.valid),
    .out_blue      (pix_out.blue_out),
    .out_green     (pix_out.green_out),
    .out_red       (pix_out.red_out),
    .out_kept      (pix_out.kept),
    .out_frame_end (pix_out.frame_end)
  );

endmodule

[hw/rtl/rlpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rlpf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rlpf_regs.sv]
// APB register file holding the filter settings and the clamped frame geometry.
`timescale 1ns / 1ps

module rlpf_regs import rlpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [FLOOR_W-1:0]      red_floor;
  logic [MARGIN_W-1:0]     red_margin;
  logic [RUN_NEEDED_W-1:0] run_needed;
  logic [FW_W-1:0]         frame_width;
  logic [FH_W-1:0]         frame_height;
  logic [AW_W-1:0]         active_w;
  logic [AH_W-1:0]         active_h;
  logic [POS_W-1:0]        total;

  logic [AW_W-1:0]         aw_next;
  logic [AH_W-1:0]         ah_next;
  logic [AW_W+AH_W-1:0]    prod;
  logic                    wr_en;
  reg_idx_t                idx;

  function automatic logic [AW_W-1:0] clamp_w(input logic [FW_W-1:0] v);
    logic [AW_W-1:0] r;
    if (v == '0) begin
      r = AW_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = AW_W'(MAX_WIDTH);
    end else begin
      r = AW_W'(v);
    end
    return r;
  endfunction

  function automatic logic [AH_W-1:0] clamp_h(input logic [FH_W-1:0] v);
    logic [AH_W-1:0] r;
    if (v == '0) begin
      r = AH_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = AH_W'(MAX_HEIGHT);
    end else begin
      r = AH_W'(v);
    end
    return r;
  endfunction

  assign idx     = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign aw_next = clamp_w(frame_width);
  assign ah_next = clamp_h(frame_height);
  assign prod    = (AW_W + AH_W)'(aw_next) * (AW_W + AH_W)'(ah_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_floor    <= RST_RED_FLOOR;
      red_margin   <= RST_RED_MARGIN;
      run_needed   <= RST_RUN_NEEDED;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (wr_en) begin
      case (idx)
        REG_RED_FLOOR:    red_floor    <= pwdata[FLOOR_W-1:0];
        REG_RED_MARGIN:   red_margin   <= pwdata[MARGIN_W-1:0];
        REG_RUN_NEEDED:   run_needed   <= pwdata[RUN_NEEDED_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry follows the raw registers in the next cycle.
  always_ff @(posedge clk) begin
    active_w <= aw_next;
    active_h <= ah_next;
    total    <= POS_W'(prod);
  end

  always_comb begin
    case (idx)
      REG_RED_FLOOR:    prdata = PDATA_W'(red_floor);
      REG_RED_MARGIN:   prdata = PDATA_W'(red_margin);
      REG_RUN_NEEDED:   prdata = PDATA_W'(run_needed);
      REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg.red_floor  = red_floor;
  assign cfg.red_margin = red_margin;
  assign cfg.run_needed = run_needed;
  assign cfg.active_w   = active_w;
  assign cfg.active_h   = active_h;
  assign cfg.total      = total;

endmodule

[hw/rtl/rlpf_ctrl.sv]
// Controller state machine that sequences load and readout beats through the datapath.
`timescale 1ns / 1ps

module rlpf_ctrl import rlpf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_LOAD,
    S_DIV,
    S_CRD,
    S_CCHK,
    S_DINIT,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take_item = 1'b1;
          state_next    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.pos_set = 1'b1;
        state_next  = stat.mode ? S_DIV : S_LOAD;
      end
      S_LOAD: begin
        cmd.load_write = 1'b1;
        state_next     = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        cmd.center_read = 1'b1;
        state_next      = S_CCHK;
      end
      S_CCHK: begin
        cmd.center_latch = 1'b1;
        state_next       = stat.center_red ? S_DINIT : S_FINISH;
      end
      S_DINIT: begin
        cmd.dir_init = 1'b1;
        state_next   = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          if (stat.walk_keep || stat.last_dir) begin
            state_next = S_FINISH;
          end else begin
            cmd.dir_next = 1'b1;
            state_next   = S_DINIT;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

[hw/rtl/rlpf_datapath.sv]
// Datapath: frame store, positions, coordinate divider, run walker and output register.
`timescale 1ns / 1ps

module rlpf_datapath import rlpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  cfg_t              cfg,
  input  logic              in_mode,
  input  logic [PIX_W-1:0]  in_pix,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_red,
  output logic              out_kept,
  output logic              out_frame_end
);

  // Item and position registers.
  logic                 mode_q;
  logic [PIX_W-1:0]     pix_q;
  logic [POS_W-1:0]     load_pos;
  logic [POS_W-1:0]     read_pos;
  logic [POS_W-1:0]     cur_pos;

  // Restoring divider: cur_pos / active_w gives the row, the remainder the column.
  logic [AW_W-1:0]      rem;
  logic [POS_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Center pixel and run walker.
  logic [PIX_W-1:0]     center;
  logic                 center_red_q;
  logic [1:0]           dir;
  logic [POS_W-1:0]     addr;
  logic [RUN_W-1:0]     limit;
  logic [RUN_W-1:0]     issued;
  logic [RUN_W-1:0]     count;
  logic                 pend;
  logic                 keep;

  logic [POS_W-1:0]     pos_src;
  logic [POS_W-1:0]     pos_eff;
  logic [POS_W-1:0]     pos_inc;
  logic [POS_W-1:0]     pos_wrap;
  logic [AW_W:0]        r_sh;
  logic [AW_W:0]        aw_ext;
  logic                 div_ge;
  logic [AW_W-1:0]      rem_next;
  logic [DIST_W-1:0]    reach;
  logic [RUN_W-1:0]     limit_next;
  logic [POS_W-1:0]     addr_next;
  logic [RUN_W-1:0]     count_inc;
  logic                 issue_ok;
  logic                 run_hit;
  logic                 rd_red;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [PIX_W-1:0]     ram_rdata;

  function automatic logic is_red(input logic [PIX_W-1:0]    p,
                                  input logic [FLOOR_W-1:0]  fl,
                                  input logic [MARGIN_W-1:0] mg);
    logic [CHAN_W:0] b;
    logic [CHAN_W:0] g;
    logic [CHAN_W:0] r;
    b = {1'b0, p[CHAN_W-1:0]};
    g = {1'b0, p[2*CHAN_W-1:CHAN_W]};
    r = {1'b0, p[3*CHAN_W-1:2*CHAN_W]};
    return (r > (CHAN_W+1)'(fl)) && (r > g + (CHAN_W+1)'(mg)) && (r > b + (CHAN_W+1)'(mg));
  endfunction

  assign pos_src  = mode_q ? read_pos : load_pos;
  assign pos_eff  = (pos_src >= cfg.total) ? '0 : pos_src;
  assign pos_inc  = cur_pos + POS_W'(1);
  assign pos_wrap = (pos_inc >= cfg.total) ? '0 : pos_inc;

  assign r_sh     = {rem, quo[POS_W-1]};
  assign aw_ext   = {1'b0, cfg.active_w};
  assign div_ge   = (r_sh >= aw_ext);
  assign rem_next = div_ge ? AW_W'(r_sh - aw_ext) : r_sh[AW_W-1:0];

  // Distance to the frame edge in the current direction: right, left, down, up.
  always_comb begin
    case (dir)
      2'd0:    reach = DIST_W'(cfg.active_w) - DIST_W'(rem) - DIST_W'(1);
      2'd1:    reach = DIST_W'(rem);
      2'd2:    reach = DIST_W'(cfg.active_h) - DIST_W'(quo[AH_W-1:0]) - DIST_W'(1);
      default: reach = DIST_W'(quo[AH_W-1:0]);
    endcase
  end

  assign limit_next = (int'(reach) > MAX_RUN) ? RUN_W'(MAX_RUN) : RUN_W'(reach);

  always_comb begin
    case (dir)
      2'd0:    addr_next = addr + POS_W'(1);
      2'd1:    addr_next = addr - POS_W'(1);
      2'd2:    addr_next = addr + POS_W'(cfg.active_w);
      default: addr_next = addr - POS_W'(cfg.active_w);
    endcase
  end

  assign rd_red    = is_red(ram_rdata, cfg.red_floor, cfg.red_margin);
  assign count_inc = count + RUN_W'(1);
  assign issue_ok  = (issued < limit);
  assign run_hit   = (int'(count_inc) > int'(cfg.run_needed));

  assign ram_we    = cmd.load_write;
  assign ram_raddr = cmd.center_read ? cur_pos[ADDR_W-1:0] : addr_next[ADDR_W-1:0];

  rlpf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_pos[ADDR_W-1:0]),
    .wdata (pix_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos  <= '0;
      read_pos  <= '0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
      pend      <= 1'b0;
      keep      <= 1'b0;
      dir       <= '0;
    end else begin
      if (cmd.load_write) begin
        load_pos <= pos_wrap;
      end
      if (cmd.pos_set) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.center_latch) begin
        dir  <= '0;
        keep <= 1'b0;
      end else if (cmd.dir_next) begin
        dir <= dir + 2'd1;
      end
      if (cmd.dir_init) begin
        pend <= 1'b0;
      end else if (cmd.walk_step) begin
        pend <= issue_ok;
        if (pend && rd_red && run_hit) begin
          keep <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        read_pos  <= pos_wrap;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      mode_q <= in_mode;
      pix_q  <= in_pix;
    end
    if (cmd.pos_set) begin
      cur_pos <= pos_eff;
      rem     <= '0;
      quo     <= pos_eff;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= {quo[POS_W-2:0], div_ge};
    end
    if (cmd.center_latch) begin
      center       <= ram_rdata;
      center_red_q <= rd_red;
    end
    if (cmd.dir_init) begin
      addr   <= cur_pos;
      limit  <= limit_next;
      issued <= '0;
      count  <= '0;
    end else if (cmd.walk_step) begin
      if (issue_ok) begin
        addr   <= addr_next;
        issued <= issued + RUN_W'(1);
      end
      if (pend && rd_red) begin
        count <= count_inc;
      end
    end
    if (cmd.emit) begin
      out_blue      <= keep ? center[CHAN_W-1:0] : '0;
      out_green     <= keep ? center[2*CHAN_W-1:CHAN_W] : '0;
      out_red       <= keep ? center[3*CHAN_W-1:2*CHAN_W] : '0;
      out_kept      <= keep;
      out_frame_end <= (pos_inc == cfg.total);
    end
  end

  assign stat.mode       = mode_q;
  assign stat.div_done   = (div_cnt == DIV_CNT_W'(POS_W - 1));
  assign stat.center_red = rd_red;
  assign stat.walk_done  = pend ? (!rd_red || run_hit || (count_inc == limit)) : !issue_ok;
  assign stat.walk_keep  = pend && rd_red && run_hit;
  assign stat.last_dir   = (dir == 2'd3);
  assign stat.out_free   = !out_valid || out_ready;

`ifndef SYNTH
  // A pixel is only ever kept when the center pixel itself passed the red test.
  a_keep_needs_red: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && keep) |-> center_red_q)
    else $error("kept pixel whose center is not red");

  // The walker never reads outside the active frame.
  a_walk_in_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_step && issue_ok) |-> (addr_next < cfg.total))
    else $error("run walker address beyond frame");

  // Loads land inside the active frame.
  a_load_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.load_write |-> (cur_pos < cfg.total))
    else $error("load position beyond frame");

  // A run never counts past its edge-limited length.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> ((count <= limit) && (issued <= limit)))
    else $error("run count exceeds limit");
`endif

endmodule
